// File: hdl/qpe_pkg.sv
// Shared types, character codes and helpers for the quoted-printable encoder.
package qpe_pkg;

    localparam int          MAX_CHARS      = 5;
    localparam int          COUNT_W        = 3;
    localparam int          COLUMN_W       = 9;
    localparam logic [7:0]  LIMIT_RESET    = 8'd70;

    localparam logic [7:0]  CH_EQUALS      = 8'h3D;
    localparam logic [7:0]  CH_NEWLINE     = 8'h0A;
    localparam logic [7:0]  CH_SPACE       = 8'h20;
    localparam logic [7:0]  CH_TAB         = 8'h09;
    localparam logic [7:0]  CH_PRINT_LO    = 8'd33;
    localparam logic [7:0]  CH_PRINT_HI    = 8'd126;

    localparam logic        REG_LINE_LIMIT = 1'b0;

    // Characters produced by one input byte, in emission order.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [COUNT_W-1:0]        count;
    } qpe_expand_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'd0, nib};
        if (nib < 4'd10)
            return 8'h30 + n8;
        else
            return 8'h37 + n8;
    endfunction

endpackage

// File: hdl/qpe_encode.sv
// Line state and expansion of one input byte into its output characters.
module qpe_encode
    import qpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic [7:0]  line_limit,
    output qpe_expand_t expand
);

    logic [COLUMN_W-1:0] column_reg, column_next;
    logic                blank_reg, blank_next;

    logic                soft_break;
    logic                is_print;
    logic                is_blank;
    logic [COLUMN_W-1:0] col_base;
    logic [2:0][7:0]     body;
    logic [COUNT_W-1:0]  body_count;

    always_comb
    begin
        is_print   = (in_byte >= CH_PRINT_LO) && (in_byte <= CH_PRINT_HI)
                     && (in_byte != CH_EQUALS);
        is_blank   = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
        soft_break = column_reg > {1'b0, line_limit};
        col_base   = soft_break ? '0 : column_reg;

        if (is_print || is_blank)
        begin
            body       = {8'h00, 8'h00, in_byte};
            body_count = 3'd1;
        end
        else
        begin
            body       = {hex_digit(in_byte[3:0]), hex_digit(in_byte[7:4]), CH_EQUALS};
            body_count = 3'd3;
        end

        expand.chars = '0;
        if (in_byte == CH_NEWLINE)
        begin
            if (blank_reg)
            begin
                expand.chars[0] = CH_EQUALS;
                expand.chars[1] = CH_NEWLINE;
                expand.chars[2] = CH_NEWLINE;
                expand.count    = 3'd3;
            end
            else
            begin
                expand.chars[0] = CH_NEWLINE;
                expand.count    = 3'd1;
            end
            column_next = '0;
            blank_next  = 1'b0;
        end
        else
        begin
            if (soft_break)
            begin
                expand.chars[0] = CH_EQUALS;
                expand.chars[1] = CH_NEWLINE;
                expand.chars[2] = body[0];
                expand.chars[3] = body[1];
                expand.chars[4] = body[2];
                expand.count    = body_count + 3'd2;
            end
            else
            begin
                expand.chars[0] = body[0];
                expand.chars[1] = body[1];
                expand.chars[2] = body[2];
                expand.count    = body_count;
            end
            column_next = col_base + {{(COLUMN_W-COUNT_W){1'b0}}, body_count};
            blank_next  = is_blank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            blank_reg  <= 1'b0;
        end
        else if (accept)
        begin
            column_reg <= column_next;
            blank_reg  <= blank_next;
        end
    end

endmodule

// File: hdl/qpe_emit.sv
// Expansion slot and output register: streams the characters of one byte, one per cycle while the receiver is ready.
module qpe_emit
    import qpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  qpe_expand_t expand,
    output logic        take_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last
);

    qpe_expand_t        slot_reg;
    logic               slot_valid_reg, slot_valid_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               last_reg;

    logic               advance;
    logic               slot_last;

    assign slot_last = idx_reg == (slot_reg.count - 3'd1);
    assign advance   = slot_valid_reg && (!out_valid_reg || out_ready);
    assign take_ok   = !slot_valid_reg || (advance && slot_last);

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        idx_next        = idx_reg;
        if (accept)
        begin
            slot_valid_next = 1'b1;
            idx_next        = '0;
        end
        else if (advance && slot_last)
            slot_valid_next = 1'b0;
        else if (advance)
            idx_next = idx_reg + 3'd1;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            slot_reg <= expand;
        if (advance)
        begin
            out_byte_reg <= slot_reg.chars[idx_reg];
            last_reg     <= slot_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

// File: hdl/quoted_printable_encoder.sv
// Top level of the quoted-printable encoder: config register and stage wiring.
//
// Input channel: in_valid/in_ready carry one raw byte (in_byte) per transfer.
// Output channel: out_valid/out_ready carry one encoded character (out_byte)
// per transfer; last marks the final character caused by one input byte.
// A byte gives one character (plain), three (escape "=XX", or "=\n\n" at a
// newline after a blank) or up to five when a soft break "=\n" comes first.
// The first character of a byte passes through the expansion slot and
// then the output register. Throughput: one output character per cycle
// while the receiver is ready, so an input byte is taken every cycle
// while bytes expand to one character; a longer expansion holds the
// input until its last character is loaded into the output register,
// set by the single expansion slot feeding the output register.
// The output register lets the next byte be taken while a character waits.
// When the receiver stalls, the output holds and the input stalls once the
// slot is busy. Reset clears the column, the blank flag and all valids, and
// sets line_limit to 70. line_limit is written over APB at address 0 and
// should only change while the block is idle.
module quoted_printable_encoder
    import qpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last
);

    logic [7:0]  line_limit_reg;
    logic        accept;
    logic        take_ok;
    qpe_expand_t expand;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LINE_LIMIT) ? {24'd0, line_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_LIMIT)
            line_limit_reg <= pwdata[7:0];
    end

    assign in_ready = take_ok;
    assign accept   = in_valid && take_ok;

    qpe_encode u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .line_limit (line_limit_reg),
        .expand     (expand)
    );

    qpe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .expand    (expand),
        .take_ok   (take_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// File: hdl/qpe_checker.sv
// Port-level checks for the quoted-printable encoder and their bind.
module qpe_checker
    import qpe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last
);

    logic       out_fire;
    logic [7:0] prev_byte_reg;
    logic       prev_last_reg;

    assign out_fire = out_valid && out_ready;

    // Remember the previous output transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg <= 8'h00;
            prev_last_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            prev_byte_reg <= out_byte;
            prev_last_reg <= last;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output changed while stalled");

    // Check while reset stays asserted, once the registers have settled.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !out_valid && pready)
        else $error("output valid during reset");

    a_break_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_byte == CH_NEWLINE && !last |-> prev_byte_reg == CH_EQUALS)
        else $error("non-final newline without preceding equals sign");

    a_escape_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && prev_byte_reg == CH_EQUALS && !prev_last_reg |->
            out_byte == CH_NEWLINE
            || (out_byte >= 8'h30 && out_byte <= 8'h39)
            || (out_byte >= 8'h41 && out_byte <= 8'h46))
        else $error("equals sign followed by an illegal character");

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
);
